FILE: hdl/proof_nonce_bit_unpacker_defines.svh
// Assertion helpers for the file that checks its own logic.
// The sampling clock is i_clk and the checks are off while i_rst_n is low.
`ifndef PROOF_NONCE_BIT_UNPACKER_DEFINES_SVH
`define PROOF_NONCE_BIT_UNPACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNBU_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PNBU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pnbu_pkg.sv
package pnbu_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned NONCE_W        = 63;
    localparam int unsigned IDX_W          = 6;
    localparam int unsigned WIDTH_W        = 6;
    localparam int unsigned PROOF_SIZE_DEF = 42;

    // Queue between the front and the back; a power of two.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_START_OK  = 2'd1,
        KIND_START_BAD = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
    } t_entry;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_COLLECT = 2'd1,
        PHASE_DONE    = 2'd2
    } t_phase;

endpackage

FILE: hdl/pnbu_in_if.sv
interface pnbu_in_if import pnbu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

FILE: hdl/pnbu_out_if.sv
interface pnbu_out_if import pnbu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NONCE_W-1:0] nonce;
    logic [IDX_W-1:0]   nonce_index;
    logic               last;
    logic               error;

    modport source (output valid, output nonce, output nonce_index, output last,
                    output error, input ready);
    modport sink   (input valid, input nonce, input nonce_index, input last,
                    input error, output ready);
endinterface

FILE: hdl/pnbu_front.sv
module pnbu_front import pnbu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pnbu_in_if.sink    i_in,
    input  logic       i_pop,
    output logic       o_head_valid,
    output t_entry     o_head
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              w_push;
    logic              w_pop;
    logic              w_bad_width;
    t_entry            w_entry;

    // A header is bad when its width is zero or does not fit in six bits.
    assign w_bad_width = (i_in.data_byte == '0) || (i_in.data_byte[BYTE_W-1:WIDTH_W] != '0);

    always_comb begin
        w_entry.data = i_in.data_byte;
        if (!i_in.start_req) begin
            w_entry.kind = KIND_DATA;
        end else if (w_bad_width) begin
            w_entry.kind = KIND_START_BAD;
        end else begin
            w_entry.kind = KIND_START_OK;
        end
    end

    assign i_in.ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push       = i_in.valid && i_in.ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/pnbu_back.sv
module pnbu_back import pnbu_pkg::*; #(
    parameter int unsigned PROOF_SIZE = PROOF_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_entry     i_head,
    output logic       o_pop,
    pnbu_out_if.source o_out
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [WIDTH_W-1:0] r_width;
    logic [WIDTH_W-1:0] n_width;
    logic [NONCE_W-1:0] r_partial;
    logic [NONCE_W-1:0] n_partial;
    logic [WIDTH_W-1:0] r_gathered;
    logic [WIDTH_W-1:0] n_gathered;
    logic [IDX_W-1:0]   r_done;
    logic [IDX_W-1:0]   n_done;
    logic [2:0]         r_pos;
    logic [2:0]         n_pos;

    logic               r_out_valid;
    logic               n_out_valid;
    logic [NONCE_W-1:0] r_nonce;
    logic [NONCE_W-1:0] n_nonce;
    logic [IDX_W-1:0]   r_index;
    logic [IDX_W-1:0]   n_index;
    logic               r_last;
    logic               n_last;
    logic               r_error;
    logic               n_error;

    logic               w_slot_free;
    logic               w_collect;
    logic [3:0]         w_avail;
    logic [WIDTH_W-1:0] w_need;
    logic               w_fits;
    logic [3:0]         w_take;
    logic [8:0]         w_mask;
    logic [BYTE_W-1:0]  w_bits;
    logic [NONCE_W-1:0] w_merged;
    logic [3:0]         w_pos_sum;
    logic               w_is_last;
    logic               w_emit_data;
    logic               w_emit_bad;
    logic               w_go;

    // Bits of the head byte still to be consumed, and bits the nonce still needs.
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_collect   = (r_phase == PHASE_COLLECT);
    assign w_avail     = 4'd8 - {1'b0, r_pos};
    assign w_need      = r_width - r_gathered;
    assign w_fits      = (w_need <= {2'b00, w_avail});
    assign w_take      = w_fits ? w_need[3:0] : w_avail;
    assign w_mask      = (9'd1 << w_take) - 9'd1;
    assign w_bits      = (i_head.data >> r_pos) & w_mask[BYTE_W-1:0];
    assign w_merged    = r_partial | ({{(NONCE_W-BYTE_W){1'b0}}, w_bits} << r_gathered);
    assign w_pos_sum   = {1'b0, r_pos} + w_need[3:0];
    assign w_is_last   = ({1'b0, r_done} + 7'd1) >= 7'(PROOF_SIZE);

    assign w_emit_data = i_head_valid && (i_head.kind == KIND_DATA) && w_collect && w_fits;
    assign w_emit_bad  = i_head_valid && (i_head.kind == KIND_START_BAD);
    assign w_go        = i_head_valid && (w_slot_free || !(w_emit_data || w_emit_bad));

    always_comb begin
        n_phase = r_phase;
        if (w_go) begin
            case (i_head.kind)
                KIND_START_OK:  n_phase = PHASE_COLLECT;
                KIND_START_BAD: n_phase = PHASE_IDLE;
                KIND_DATA: begin
                    if (w_emit_data && w_is_last) begin
                        n_phase = PHASE_DONE;
                    end
                end
                default:        n_phase = r_phase;
            endcase
        end
    end

    always_comb begin
        n_width    = r_width;
        n_partial  = r_partial;
        n_gathered = r_gathered;
        n_done     = r_done;
        n_pos      = r_pos;
        o_pop      = 1'b0;
        if (w_go) begin
            case (i_head.kind)
                KIND_START_OK: begin
                    n_width    = i_head.data[WIDTH_W-1:0];
                    n_partial  = '0;
                    n_gathered = '0;
                    n_done     = '0;
                    n_pos      = '0;
                    o_pop      = 1'b1;
                end
                KIND_START_BAD: begin
                    n_partial  = '0;
                    n_gathered = '0;
                    n_done     = '0;
                    n_pos      = '0;
                    o_pop      = 1'b1;
                end
                KIND_DATA: begin
                    if (!w_collect) begin
                        n_pos = '0;
                        o_pop = 1'b1;
                    end else if (!w_fits) begin
                        // The rest of the byte goes into the partial nonce.
                        n_partial  = w_merged;
                        n_gathered = r_gathered + WIDTH_W'(w_avail);
                        n_pos      = '0;
                        o_pop      = 1'b1;
                    end else begin
                        n_partial  = '0;
                        n_gathered = '0;
                        n_done     = r_done + IDX_W'(1);
                        if (w_is_last || (w_pos_sum == 4'd8)) begin
                            n_pos = '0;
                            o_pop = 1'b1;
                        end else begin
                            n_pos = w_pos_sum[2:0];
                        end
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_nonce     = r_nonce;
        n_index     = r_index;
        n_last      = r_last;
        n_error     = r_error;
        if (w_go && w_emit_bad) begin
            n_out_valid = 1'b1;
            n_nonce     = '0;
            n_index     = '0;
            n_last      = 1'b1;
            n_error     = 1'b1;
        end else if (w_go && w_emit_data) begin
            n_out_valid = 1'b1;
            n_nonce     = w_merged;
            n_index     = r_done;
            n_last      = w_is_last;
            n_error     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_IDLE;
            r_width     <= '0;
            r_partial   <= '0;
            r_gathered  <= '0;
            r_done      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_width     <= n_width;
            r_partial   <= n_partial;
            r_gathered  <= n_gathered;
            r_done      <= n_done;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nonce <= n_nonce;
        r_index <= n_index;
        r_last  <= n_last;
        r_error <= n_error;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.nonce       = r_nonce;
    assign o_out.nonce_index = r_index;
    assign o_out.last        = r_last;
    assign o_out.error       = r_error;

endmodule

FILE: hdl/proof_nonce_bit_unpacker.sv
// Proof nonce unpacker. Serialized proof words arrive on i_in, one byte per
// word: a word with start_req set is a header holding the nonce width, and the
// words after it are data read least significant bit first. Each time the
// width is reached a nonce leaves on o_out with its index in the proof; the
// nonce numbered PROOF_SIZE-1 carries last, and later bits and data words are
// dropped until the next header. A header of width 0 or above 63 yields one
// word with error and last set and nonce zero, after which data is dropped.
// The word completing a result is held in a queue register, and the result
// is then held in the output register that drives o_out.
// The back end does one step per cycle unless o_out stalls. A header, an
// ignored word or a data word that completes no nonce is one step. A data
// word that completes k nonces takes k steps, plus one when bits are left
// over for the next nonce. Words flow one per cycle while each word is a
// single step and o_out does not stall; a word ending a nonce mid-byte takes
// an extra step, and the four-word queue absorbs this until it fills.
// Reset (synchronous, active low) empties the queue, drops any pending result
// and returns to the idle phase, so data before the first header is dropped.
// When the receiver stalls, the result holds in the output register, the back
// end stops at its next nonce, and the queue keeps i_in ready until it fills.
module proof_nonce_bit_unpacker import pnbu_pkg::*; #(
    parameter int unsigned PROOF_SIZE = PROOF_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pnbu_in_if.sink    i_in,
    pnbu_out_if.source o_out
);

`include "proof_nonce_bit_unpacker_defines.svh"

    // Front end classifies each word and holds it in a short queue; the back
    // end walks the queued bytes and runs the nonce assembly.
    logic   w_head_valid;
    t_entry w_head;
    logic   w_pop;

    pnbu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    pnbu_back #(
        .PROOF_SIZE (PROOF_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

    // An error result carries no nonce and always closes the proof.
    `PNBU_ASSERT_SAME(a_error_shape, o_out.valid && o_out.error,
        o_out.last && (o_out.nonce == '0) && (o_out.nonce_index == '0),
        "error result with nonzero payload or without last")

    // Nonce indexes never run past the proof size.
    `PNBU_ASSERT_SAME(a_index_range, o_out.valid && !o_out.error,
        ({1'b0, o_out.nonce_index} < 7'(PROOF_SIZE)), "nonce index beyond proof size")

    // The last mark of a good proof sits exactly on its final nonce.
    `PNBU_ASSERT_SAME(a_last_index, o_out.valid && !o_out.error,
        o_out.last == ({1'b0, o_out.nonce_index} == 7'(PROOF_SIZE - 1)),
        "last mark not on final nonce")

    // Nothing is popped from an empty queue.
    `PNBU_ASSERT_SAME(a_pop_nonempty, w_pop, w_head_valid, "pop from empty queue")

endmodule

FILE: bench/testbench.sv
module testbench import pnbu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default proof length. The predictor uses the
    // same length.
    localparam int unsigned PROOF_LEN = PROOF_SIZE_DEF;
    localparam int unsigned MAX_NONCE_W = 63;
    // Cycles in which no word moves on either side before the run is abandoned.
    // The longest correct gap is a run of sender idles or receiver stalls, which
    // at 84 in a hundred stays well below this limit.
    localparam int unsigned STALL_LIMIT = 2000;
    // Quiet cycles after the last expected word. This covers the queue and output
    // registers and a full queue of bytes that each complete eight nonces.
    localparam int unsigned TAIL_CYCLES = 48;

    // One word as it leaves the unpacker.
    typedef struct packed {
        logic [NONCE_W-1:0] nonce;
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic               error;
    } t_nonce_word;

    logic clk;
    logic rst_n;

    pnbu_in_if  in_if();
    pnbu_out_if out_if();

    proof_nonce_bit_unpacker #(
        .PROOF_SIZE (PROOF_LEN)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Unpacker state as the bench sees it. It advances once per accepted byte.
    logic [WIDTH_W-1:0] width_m;
    logic [NONCE_W-1:0] partial_m;
    logic [WIDTH_W-1:0] gathered_m;
    logic [IDX_W-1:0]   done_m;
    t_phase             phase_m;

    // Words that the unpacker still owes, oldest first.
    t_nonce_word expected_nonces[$];

    // Idling settings of the current phase, in percent.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned sent_bytes;
    int unsigned taken_bytes;
    int unsigned words_checked;
    int unsigned mismatch_count;
    int unsigned good_headers;
    int unsigned bad_headers;
    int unsigned proofs_closed;
    int unsigned idle_cycles;

    t_nonce_word want;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predicts the words caused by one accepted byte. It returns 1 when the
    // unpacker acts on the byte, and 0 when the byte is dropped.
    function automatic bit unpack_byte(input logic [BYTE_W-1:0] b, input logic s);
        logic lst;
        if (s) begin
            // A header always restarts, even in the middle of a proof.
            partial_m  = '0;
            gathered_m = '0;
            done_m     = '0;
            if (b == 0 || b > MAX_NONCE_W) begin
                phase_m = PHASE_IDLE;
                bad_headers++;
                expected_nonces.insert(expected_nonces.size(),
                                       '{nonce: '0, idx: '0, last: 1'b1, error: 1'b1});
            end else begin
                width_m = b[WIDTH_W-1:0];
                phase_m = PHASE_COLLECT;
                good_headers++;
            end
            return 1'b1;
        end
        // Data outside a proof is dropped without a word.
        if (phase_m != PHASE_COLLECT)
            return 1'b0;
        // The bits are taken least significant first. Once the final nonce is
        // out, the rest of the byte is dropped.
        for (int k = 0; k < BYTE_W && phase_m == PHASE_COLLECT; k++) begin
            if (b[k])
                partial_m[gathered_m] = 1'b1;
            gathered_m++;
            if (gathered_m >= width_m) begin
                lst = (int'(done_m) + 1 >= PROOF_LEN);
                expected_nonces.insert(expected_nonces.size(),
                                       '{nonce: partial_m, idx: done_m, last: lst,
                                         error: 1'b0});
                done_m++;
                partial_m  = '0;
                gathered_m = '0;
                if (lst) begin
                    phase_m = PHASE_DONE;
                    proofs_closed++;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 exp_val);
        mismatch_count++;
    endtask

    // Sends one word and waits for its handshake. The valid line stays high
    // after a handshake, so back-to-back words need only one assignment per edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.start_req <= s;
        do @(posedge clk); while (!in_if.ready);
        sent_bytes++;
        if (unpack_byte(b, s))
            taken_bytes++;
    endtask

    // Lowers valid and holds off until every owed word has arrived. It always
    // waits for a clock edge, so the next word is driven in a later time step.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (expected_nonces.size() != 0);
    endtask

    // Mostly random data, with all-zero and all-one bytes mixed in.
    function automatic logic [BYTE_W-1:0] pick_data();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        return BYTE_W'($urandom_range(255));
    endfunction

    // A header of width w followed by n data bytes.
    task automatic send_proof(input int unsigned w, input int unsigned n);
        send_byte(BYTE_W'(w), 1'b1);
        for (int unsigned k = 0; k < n; k++)
            send_byte(pick_data(), 1'b0);
    endtask

    // The receiver stalls at the rate of the current phase.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted word is checked field by field against the oldest
    // expectation.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            words_checked++;
            if (expected_nonces.size() == 0) begin
                report_mismatch("unexpected word, nonce", 64'(out_if.nonce), 64'd0);
            end else begin
                want = expected_nonces.pop_front();
                if (out_if.nonce !== want.nonce)
                    report_mismatch("nonce", 64'(out_if.nonce), 64'(want.nonce));
                if (out_if.nonce_index !== want.idx)
                    report_mismatch("nonce_index", 64'(out_if.nonce_index), 64'(want.idx));
                if (out_if.last !== want.last)
                    report_mismatch("last", 64'(out_if.last), 64'(want.last));
                if (out_if.error !== want.error)
                    report_mismatch("error", 64'(out_if.error), 64'(want.error));
            end
        end
    end

    // The watchdog ends the run when nothing moves on either side for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d words still owed",
                 STALL_LIMIT, expected_nonces.size());
        $display("FAILURE");
        $finish;
    end

    // Data before any header must be dropped.
    task automatic test_data_before_header();
        send_byte(8'hA5, 1'b0);
    endtask

    // Headers of width zero and above the widest nonce each give one error word.
    // The data after them is dropped.
    task automatic test_bad_header();
        send_byte(8'd0, 1'b1);
        send_byte(8'd64, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
    endtask

    // Width one: each byte gives eight nonces until the proof is complete. The
    // sixth byte closes it after two bits, and the rest of that byte is
    // dropped, as is the byte that follows it.
    task automatic test_width_one_proof();
        send_byte(8'd1, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF3, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // The widest nonce: eight bytes of ones give one all-ones nonce. One bit
    // is carried into the next nonce.
    task automatic test_widest_nonce();
        send_byte(8'd63, 1'b1);
        for (int k = 0; k < 8; k++)
            send_byte(8'hFF, 1'b0);
    endtask

    // A new header in the middle of a proof drops the partial nonce that was
    // carried over from the widest nonce test.
    task automatic test_header_mid_proof();
        send_byte(8'd5, 1'b1);
        send_byte(8'h21, 1'b0);
        send_byte(8'hC4, 1'b0);
    endtask

    // Random traffic: well-formed proofs with random content, proofs that a new
    // header may cut short, bad headers and loose noise. The loop stops once
    // enough bytes have been acted on.
    task automatic test_random_proofs(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned quota);
        int unsigned first_taken;
        int unsigned r;
        int unsigned w;
        int unsigned n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_taken    = taken_bytes;
        while (taken_bytes - first_taken < quota) begin
            r = $urandom_range(99);
            if (r < 40) begin
                // Full proofs use small widths so that they stay short. A few
                // trailing bytes check that the closed proof drops them.
                w = ($urandom_range(3) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
                send_proof(w, (PROOF_LEN * w + BYTE_W - 1) / BYTE_W);
                for (int unsigned k = $urandom_range(2); k > 0; k--)
                    send_byte(pick_data(), 1'b0);
            end else if (r < 75) begin
                // This proof may be cut short by whatever header comes next.
                w = ($urandom_range(1) == 0) ? $urandom_range(63, 32) : $urandom_range(31, 1);
                n = $urandom_range(12, 1);
                send_proof(w, n);
            end else if (r < 85) begin
                w = ($urandom_range(3) == 0) ? 0 : $urandom_range(255, 64);
                send_byte(BYTE_W'(w), 1'b1);
                for (int unsigned k = $urandom_range(2); k > 0; k--)
                    send_byte(pick_data(), 1'b0);
            end else begin
                for (int unsigned k = $urandom_range(4, 1); k > 0; k--)
                    send_byte(pick_data(), ($urandom_range(7) == 0));
            end
        end
        // The sender holds off here until the unpacker has caught up.
        wait_for_drain();
    endtask

    initial begin
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        in_if.start_req <= 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        sent_bytes      = 0;
        taken_bytes     = 0;
        words_checked   = 0;
        mismatch_count  = 0;
        good_headers    = 0;
        bad_headers     = 0;
        proofs_closed   = 0;

        // The reset state matches the initial state of the predictor.
        width_m    = '0;
        partial_m  = '0;
        gathered_m = '0;
        done_m     = '0;
        phase_m    = PHASE_IDLE;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_data_before_header();
        test_bad_header();
        test_width_one_proof();
        test_widest_nonce();
        test_header_mid_proof();
        wait_for_drain();

        test_random_proofs(0, 0, 28);
        test_random_proofs(84, 0, 28);
        test_random_proofs(0, 84, 28);
        test_random_proofs(36, 36, 28);

        // Any word after the last expectation is caught by the checker here.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d bytes, %0d acted on; %0d good and %0d bad headers",
                 sent_bytes, taken_bytes, good_headers, bad_headers);
        $display("checked %0d nonce words, %0d full proofs, %0d mismatches",
                 words_checked, proofs_closed, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
